### hw/rtl/mne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mne_pkg: shared types and constants of the mesh normal engine
// Word layouts of both channels, store entry layout and fixed-point limits.
// ----------------------------------------------------------------------------
package mne_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);
    localparam int POS_W        = 24;
    localparam int NRM_W        = 16;
    localparam int VEC_W        = 52;
    localparam int ONE_Q14      = 16384;

    typedef logic [IDX_W-1:0] vidx_t;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_TRI  = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]              func;
        logic [9:0]              first_index;
        logic [9:0]              second_index;
        logic [9:0]              third_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] norm_x;
        logic signed [NRM_W-1:0] norm_y;
        logic signed [NRM_W-1:0] norm_z;
        logic                    degenerate;
    } out_word_t;

    // one store entry: a position (Q11.12) or a normal sum (Q9.14)
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } trip_t;

    // vector handed to the normalizer, two's complement per component
    typedef logic [2:0][VEC_W-1:0] vec3_t;

    // reduce an index to the vertex range
    function automatic vidx_t pick_vertex(input logic [9:0] idx);
        return vidx_t'(32'(idx) % VERTEX_COUNT);
    endfunction

endpackage

### hw/rtl/mne_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mne_normalize: iterative vector normalizer
// Scales a 3-vector to 30-bit magnitudes, sums squares on one multiplier,
// takes a bit-pair square root and divides each component bit-serially.
// ----------------------------------------------------------------------------
module mne_normalize (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  mne_pkg::vec3_t    vec,
    output logic              done,
    output mne_pkg::out_word_t res
);
    import mne_pkg::*;

    localparam int MAG_W = VEC_W;
    localparam int SQ_W  = 62;
    localparam int REM_W = 47;
    localparam int LEN_W = 32;
    localparam int QUO_W = 15;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQUARE, N_SQRT, N_DSET, N_DIV
    } nstate_t;

    nstate_t              state_reg, state_next;
    logic [MAG_W-1:0]     mag_reg [3];
    logic [MAG_W-1:0]     mag_next [3];
    logic [2:0]           neg_reg, neg_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [1:0]           comp_reg, comp_next;
    logic [59:0]          prod_reg, prod_next;
    logic [SQ_W-1:0]      acc_reg, acc_next;
    logic [SQ_W-1:0]      root_reg, root_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    out_word_t            res_reg, res_next;
    logic                 done_reg, done_next;

    logic [MAG_W-1:0]     in_mag [3];
    logic                 hi_any, all_zero;
    logic [29:0]          op_mag;
    logic [SQ_W-1:0]      sq_bit, sq_trial;
    logic [REM_W-1:0]     div_shift;
    logic                 div_take;
    logic [QUO_W-1:0]     quo_upd, quo_sat;
    logic signed [NRM_W-1:0] comp_val;

    // magnitudes of the incoming vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_mag[i] = vec[i][VEC_W-1] ? (MAG_W'(0) - vec[i]) : vec[i];
        end
    end

    // datapath helpers
    always_comb begin
        hi_any   = (|mag_reg[0][MAG_W-1:30]) | (|mag_reg[1][MAG_W-1:30])
                 | (|mag_reg[2][MAG_W-1:30]);
        all_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        case (comp_reg)
            2'd0:    op_mag = mag_reg[0][29:0];
            2'd1:    op_mag = mag_reg[1][29:0];
            default: op_mag = mag_reg[2][29:0];
        endcase
        sq_bit    = SQ_W'(1) << {cnt_reg, 1'b0};
        sq_trial  = root_reg + sq_bit;
        div_shift = REM_W'(root_reg[LEN_W-1:0]) << cnt_reg[3:0];
        div_take  = (rem_reg >= div_shift);
        quo_upd   = quo_reg | (div_take ? (QUO_W'(1) << cnt_reg[3:0]) : '0);
        quo_sat   = (quo_upd > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : quo_upd;
        comp_val  = neg_reg[comp_reg] ? (NRM_W'(0) - NRM_W'(quo_sat)) : NRM_W'(quo_sat);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    mag_next = in_mag;
                    for (int i = 0; i < 3; i++) neg_next[i] = vec[i][VEC_W-1];
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (all_zero) begin
                    res_next   = '{norm_x: '0, norm_y: '0, norm_z: '0, degenerate: 1'b1};
                    done_next  = 1'b1;
                    state_next = N_IDLE;
                end else if (hi_any) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end else begin
                    comp_next  = 2'd0;
                    acc_next   = '0;
                    state_next = N_SQUARE;
                end
            end
            N_SQUARE: begin
                // multiply one component, add the previous product
                prod_next = op_mag * op_mag;
                if (comp_reg != 2'd0) acc_next = acc_reg + SQ_W'(prod_reg);
                if (comp_reg == 2'd3) begin
                    cnt_next   = 5'd30;
                    root_next  = '0;
                    state_next = N_SQRT;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            N_SQRT: begin
                if (acc_reg >= sq_trial) begin
                    acc_next  = acc_reg - sq_trial;
                    root_next = (root_reg >> 1) + sq_bit;
                end else begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == 5'd0) begin
                    comp_next  = 2'd0;
                    state_next = N_DSET;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            N_DSET: begin
                // numerator: magnitude in Q14 plus half the length
                rem_next   = REM_W'({op_mag, 14'b0}) + REM_W'(root_reg[LEN_W-1:1]);
                quo_next   = '0;
                cnt_next   = 5'd14;
                state_next = N_DIV;
            end
            N_DIV: begin
                if (div_take) rem_next = rem_reg - div_shift;
                quo_next = quo_upd;
                if (cnt_reg == 5'd0) begin
                    case (comp_reg)
                        2'd0:    res_next.norm_x = comp_val;
                        2'd1:    res_next.norm_y = comp_val;
                        default: res_next.norm_z = comp_val;
                    endcase
                    if (comp_reg == 2'd2) begin
                        res_next.degenerate = 1'b0;
                        done_next  = 1'b1;
                        state_next = N_IDLE;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = N_DSET;
                    end
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    // hold state and results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### hw/rtl/mesh_normal_engine.sv
`timescale 1ns / 1ps
// Triangle word: fetches the corner positions, forms the face normal in 7 cross product steps,
// normalizes it and adds it to the normal sum of each corner by read-modify-write.
// Read word: the normalizer scales, squares, takes the root of and divides the vertex sum; an
// all-zero vector is flagged degenerate. A stalled output holds the engine until m_ready.
// One word at a time. Reset: a sweep over all 1024 vertices clears the normal sums with s_ready low.
// ----------------------------------------------------------------------------
// mesh_normal_engine: face and vertex normals of a triangle mesh
// Stores vertex positions and normal sums, forms face normals by cross
// product and normalizes face normals and vertex sums on a shared unit.
// ----------------------------------------------------------------------------
module mesh_normal_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mne_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mne_pkg::out_word_t m_data
);
    import mne_pkg::*;

    localparam int EDGE_W = POS_W + 1;
    localparam int PROD_W = 2 * EDGE_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_CROSS, S_NORM_GO, S_NORM_WAIT,
        S_SUM_RD, S_SUM_WR, S_RSUM, S_RSUM_LD, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    vidx_t       clear_idx_reg, clear_idx_next;
    vidx_t       idx_a_reg, idx_a_next, idx_b_reg, idx_b_next, idx_c_reg, idx_c_next;
    logic        tri_reg, tri_next;
    logic [2:0]  step_reg, step_next;
    trip_t       pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    vec3_t       vec_reg, vec_next;
    logic        m_valid_reg, m_valid_next;
    out_word_t   m_data_reg, m_data_next;

    trip_t       pos_mem [VERTEX_COUNT];
    trip_t       sum_mem [VERTEX_COUNT];
    trip_t       pos_rd_reg, sum_rd_reg;
    logic        pos_we, sum_we;
    vidx_t       raddr, sum_waddr;
    trip_t       sum_wdata, sum_upd;

    logic        nu_start, nu_done;
    out_word_t   nu_res;

    logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z, op_a, op_b;
    logic [2:0]  xj;
    logic [1:0]  xc;
    logic        accept;

    // add a normal component to a sum, clamp to the sum range
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] s, input logic signed [NRM_W-1:0] q);
        logic signed [POS_W:0] t;
        t = (POS_W+1)'(s) + (POS_W+1)'(q);
        if (t > $signed((POS_W+1)'(8388607))) return POS_W'(8388607);
        if (t < -$signed((POS_W+1)'(8388608))) return POS_W'(-8388608);
        return POS_W'(t);
    endfunction

    mne_normalize u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (nu_start),
        .vec     (vec_reg),
        .done    (nu_done),
        .res     (nu_res)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign nu_start = (state_reg == S_NORM_GO);

    // select the vertex for store reads by step
    always_comb begin
        case (step_reg)
            3'd0:    raddr = idx_a_reg;
            3'd1:    raddr = idx_b_reg;
            default: raddr = idx_c_reg;
        endcase
    end

    // edges and cross product operands
    always_comb begin
        e1x = EDGE_W'(pb_reg.x) - EDGE_W'(pa_reg.x);
        e1y = EDGE_W'(pb_reg.y) - EDGE_W'(pa_reg.y);
        e1z = EDGE_W'(pb_reg.z) - EDGE_W'(pa_reg.z);
        e2x = EDGE_W'(pc_reg.x) - EDGE_W'(pa_reg.x);
        e2y = EDGE_W'(pc_reg.y) - EDGE_W'(pa_reg.y);
        e2z = EDGE_W'(pc_reg.z) - EDGE_W'(pa_reg.z);
        case (step_reg)
            3'd0:    begin op_a = e1y; op_b = e2z; end
            3'd1:    begin op_a = e2y; op_b = e1z; end
            3'd2:    begin op_a = e1z; op_b = e2x; end
            3'd3:    begin op_a = e1x; op_b = e2z; end
            3'd4:    begin op_a = e1x; op_b = e2y; end
            3'd5:    begin op_a = e2x; op_b = e1y; end
            default: begin op_a = '0;  op_b = '0;  end
        endcase
        xj = step_reg - 3'd1;
        xc = xj[2:1];
    end

    // saturated sum update for the current corner
    always_comb begin
        sum_upd.x = sat_add(sum_rd_reg.x, nu_res.norm_x);
        sum_upd.y = sat_add(sum_rd_reg.y, nu_res.norm_y);
        sum_upd.z = sat_add(sum_rd_reg.z, nu_res.norm_z);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        idx_c_next     = idx_c_reg;
        tri_next       = tri_reg;
        step_next      = step_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        pc_next        = pc_reg;
        prod_next      = prod_reg;
        vec_next       = vec_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        pos_we         = 1'b0;
        sum_we         = 1'b0;
        sum_waddr      = clear_idx_reg;
        sum_wdata      = '0;
        case (state_reg)
            S_CLEAR: begin
                sum_we         = 1'b1;
                clear_idx_next = clear_idx_reg + vidx_t'(1);
                if (clear_idx_reg == vidx_t'(VERTEX_COUNT - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    idx_a_next = pick_vertex(s_data.first_index);
                    idx_b_next = pick_vertex(s_data.second_index);
                    idx_c_next = pick_vertex(s_data.third_index);
                    step_next  = '0;
                    case (s_data.func)
                        FUNC_LOAD: begin
                            pos_we    = 1'b1;
                            sum_we    = 1'b1;
                            sum_waddr = pick_vertex(s_data.first_index);
                        end
                        FUNC_TRI: begin
                            tri_next   = 1'b1;
                            state_next = S_FETCH;
                        end
                        FUNC_READ: begin
                            tri_next   = 1'b0;
                            state_next = S_RSUM;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                // read data comes from the registered store output and lags the address
                case (step_reg)
                    3'd1:    pa_next = pos_rd_reg;
                    3'd2:    pb_next = pos_rd_reg;
                    3'd3:    pc_next = pos_rd_reg;
                    default: ;
                endcase
                if (step_reg == 3'd3) begin
                    step_next  = '0;
                    state_next = S_CROSS;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_CROSS: begin
                prod_next = op_a * op_b;
                if (step_reg != 3'd0) begin
                    if (!xj[0]) vec_next[xc] = VEC_W'(prod_reg);
                    else vec_next[xc] = VEC_W'($signed(vec_reg[xc]) - VEC_W'(prod_reg));
                end
                if (step_reg == 3'd6) state_next = S_NORM_GO;
                else step_next = step_reg + 3'd1;
            end
            S_NORM_GO: begin
                state_next = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (nu_done) begin
                    step_next  = '0;
                    state_next = tri_reg ? S_SUM_RD : S_OUT;
                end
            end
            S_SUM_RD: begin
                state_next = S_SUM_WR;
            end
            S_SUM_WR: begin
                sum_we    = 1'b1;
                sum_waddr = raddr;
                sum_wdata = sum_upd;
                if (step_reg == 3'd2) begin
                    state_next = S_OUT;
                end else begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_SUM_RD;
                end
            end
            S_RSUM: begin
                state_next = S_RSUM_LD;
            end
            S_RSUM_LD: begin
                vec_next[0] = VEC_W'(sum_rd_reg.x);
                vec_next[1] = VEC_W'(sum_rd_reg.y);
                vec_next[2] = VEC_W'(sum_rd_reg.z);
                state_next  = S_NORM_GO;
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = nu_res;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clear_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            m_valid_reg   <= m_valid_next;
        end
        idx_a_reg  <= idx_a_next;
        idx_b_reg  <= idx_b_next;
        idx_c_reg  <= idx_c_next;
        tri_reg    <= tri_next;
        step_reg   <= step_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pc_reg     <= pc_next;
        prod_reg   <= prod_next;
        vec_reg    <= vec_next;
        m_data_reg <= m_data_next;
    end

    // position store
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pick_vertex(s_data.first_index)] <= '{x: s_data.pos_x,
                                                          y: s_data.pos_y,
                                                          z: s_data.pos_z};
        end
        pos_rd_reg <= pos_mem[raddr];
    end

    // normal sum store
    always_ff @(posedge aclk) begin
        if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("input accepted during sum clearing");
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        nu_done |-> (state_reg == S_NORM_WAIT))
        else $error("normalizer finished outside its wait state");
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (nu_done && nu_res.degenerate) |->
        (nu_res.norm_x == '0 && nu_res.norm_y == '0 && nu_res.norm_z == '0))
        else $error("degenerate normal with nonzero components");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the mesh normal engine
// Loads vertices, sends triangles and vertex reads through a valid/ready
// channel with random gaps and stalls, and checks every result word against
// a predictor of face normals, saturating vertex sums and normalization.
// ----------------------------------------------------------------------------
module tb;
    import mne_pkg::*;

    localparam int SET_VERTS = 24;   // vertices used by the random part

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    mesh_normal_engine dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    longint    pos_store [VERTEX_COUNT][3];
    longint    sum_store [VERTEX_COUNT][3];
    out_word_t normal_queue[$];
    int        err_count = 0;

    function automatic longint root64(longint unsigned n);
        longint unsigned rt = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= rt + b) begin
                n -= rt + b;
                rt = (rt >> 1) + b;
            end else begin
                rt >>= 1;
            end
            b >>= 2;
        end
        return rt;
    endfunction

    // unit vector in Q1.14; returns degenerate flag
    function automatic bit unit_vec(input longint v[3], output longint q[3]);
        longint unsigned mg[3], m, l2, ln, r;
        int sh;
        m = 0; l2 = 0; sh = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = v[i] < 0 ? -v[i] : v[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) begin
            q = '{0, 0, 0};
            return 1'b1;
        end
        while ((m >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
            mg[i] >>= sh;
            l2 += mg[i] * mg[i];
        end
        ln = root64(l2);
        for (int i = 0; i < 3; i++) begin
            r = (mg[i] * ONE_Q14 + ln / 2) / ln;
            if (r > ONE_Q14) r = ONE_Q14;
            q[i] = v[i] < 0 ? -longint'(r) : longint'(r);
        end
        return 1'b0;
    endfunction

    function automatic void accumulate(int idx, longint q[3]);
        longint t;
        for (int i = 0; i < 3; i++) begin
            t = sum_store[idx][i] + q[i];
            if (t > 8388607) t = 8388607;
            if (t < -8388608) t = -8388608;
            sum_store[idx][i] = t;
        end
    endfunction

    // advance the predictor by one accepted word, queue its result if any
    function automatic void predict_normal(in_word_t w);
        int a, b, c;
        longint e1[3], e2[3], v[3], q[3];
        bit dg;
        out_word_t o;
        a = pick_vertex(w.first_index);
        b = pick_vertex(w.second_index);
        c = pick_vertex(w.third_index);
        case (func_t'(w.func))
            FUNC_LOAD: begin
                pos_store[a] = '{w.pos_x, w.pos_y, w.pos_z};
                sum_store[a] = '{0, 0, 0};
                return;
            end
            FUNC_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = pos_store[b][i] - pos_store[a][i];
                    e2[i] = pos_store[c][i] - pos_store[a][i];
                end
                v[0] = e1[1] * e2[2] - e2[1] * e1[2];
                v[1] = e1[2] * e2[0] - e1[0] * e2[2];
                v[2] = e1[0] * e2[1] - e2[0] * e1[1];
                dg = unit_vec(v, q);
                accumulate(a, q);
                accumulate(b, q);
                accumulate(c, q);
            end
            FUNC_READ: begin
                v = sum_store[a];
                dg = unit_vec(v, q);
            end
            default: return;
        endcase
        o.norm_x = NRM_W'(q[0]);
        o.norm_y = NRM_W'(q[1]);
        o.norm_z = NRM_W'(q[2]);
        o.degenerate = dg;
        normal_queue.insert(normal_queue.size(), o);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // send one word after a random gap; hold it until accepted
    task automatic send_word(in_word_t w);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_normal(w);
    endtask

    function automatic in_word_t make_word(func_t f, int a, int b, int c,
                                           int x, int y, int z);
        in_word_t w;
        w.func = f;
        w.first_index = 10'(a);
        w.second_index = 10'(b);
        w.third_index = 10'(c);
        w.pos_x = POS_W'(x);
        w.pos_y = POS_W'(y);
        w.pos_z = POS_W'(z);
        return w;
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 8388607 : -8388608;
            1: return int'($urandom_range(0, 8191)) - 4096;
            default: return int'({$urandom} << 8) >>> 8;
        endcase
    endfunction

    // pick a loaded vertex within the random set
    function automatic int any_loaded();
        return $urandom_range(0, SET_VERTS - 1);
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (normal_queue.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                e = normal_queue.pop_front();
                if (m_data.norm_x !== e.norm_x)
                    report_mismatch($sformatf("norm_x %0d exp %0d",
                                              m_data.norm_x, e.norm_x));
                if (m_data.norm_y !== e.norm_y)
                    report_mismatch($sformatf("norm_y %0d exp %0d",
                                              m_data.norm_y, e.norm_y));
                if (m_data.norm_z !== e.norm_z)
                    report_mismatch($sformatf("norm_z %0d exp %0d",
                                              m_data.norm_z, e.norm_z));
                if (m_data.degenerate !== e.degenerate)
                    report_mismatch($sformatf("degenerate %0b exp %0b",
                                              m_data.degenerate, e.degenerate));
            end
        end
    end

    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) stall_left <= $urandom_range(0, 10);
        end
    end

    // directed rows: func, a, b, c, x, y, z; only the first has a typed result
    typedef struct {
        func_t f;
        int    a, b, c, x, y, z;
    } row_t;

    row_t rows[$] = '{
        '{FUNC_READ, 5, 0, 0, 0, 0, 0},           // never touched sum: degenerate
        '{FUNC_LOAD, 0, 0, 0, 0, 0, 0},
        '{FUNC_LOAD, 1, 0, 0, 4096, 0, 0},
        '{FUNC_LOAD, 2, 0, 0, 0, 4096, 0},
        '{FUNC_LOAD, 1023, 1023, 1023, 8388607, 8388607, 8388607},
        '{FUNC_LOAD, 1022, 0, 0, -8388608, -8388608, -8388608},
        '{FUNC_TRI, 0, 1, 2, 0, 0, 0},            // +z unit normal
        '{FUNC_TRI, 0, 2, 1, 0, 0, 0},            // -z unit normal
        '{FUNC_TRI, 0, 0, 1, 0, 0, 0},            // repeated corner, degenerate
        '{FUNC_READ, 0, 0, 0, 0, 0, 0},
        '{FUNC_READ, 1, 0, 0, 0, 0, 0},
        '{FUNC_TRI, 1022, 1023, 1, 0, 0, 0},      // extreme positions
        '{FUNC_TRI, 1023, 1022, 2, 0, 0, 0},
        '{FUNC_READ, 1023, 0, 0, 0, 0, 0},
        '{FUNC_NOP, 1023, 1023, 1023, -1, -1, -1},
        '{FUNC_LOAD, 3, 0, 0, 8388607, -8388608, 0},
        '{FUNC_LOAD, 4, 0, 0, -8388608, 8388607, 8388607},
        '{FUNC_TRI, 3, 4, 1022, 0, 0, 0},
        '{FUNC_READ, 3, 0, 0, 0, 0, 0},
        '{FUNC_READ, 4, 0, 0, 0, 0, 0}
    };

    initial begin
        in_word_t w;
        int a, b, c, k;
        for (int i = 0; i < VERTEX_COUNT; i++) begin
            pos_store[i] = '{0, 0, 0};
            sum_store[i] = '{0, 0, 0};
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table; the first row has a fixed answer
        foreach (rows[i]) begin
            w = make_word(rows[i].f, rows[i].a, rows[i].b, rows[i].c,
                          rows[i].x, rows[i].y, rows[i].z);
            if (i == 0) begin
                normal_queue.insert(normal_queue.size(),
                                    out_word_t'{16'sd0, 16'sd0, 16'sd0, 1'b1});
                send_word(w);
                // predictor adds the same expectation; drop the duplicate
                void'(normal_queue.pop_back());
            end else begin
                send_word(w);
            end
        end

        // load the random vertex set at the low indices; the other two indices are random
        for (int i = 0; i < SET_VERTS; i++)
            send_word(make_word(FUNC_LOAD, i, $urandom, $urandom,
                                rand_pos(), rand_pos(), rand_pos()));

        // random mix: mostly triangles over loaded vertices and reads of any vertex
        for (int n = 0; n < 430; n++) begin
            k = $urandom_range(0, 99);
            a = any_loaded();
            b = any_loaded();
            c = any_loaded();
            if (k < 50) begin
                if ($urandom_range(0, 9) == 0) b = a;
                w = make_word(FUNC_TRI, a, b, c, $urandom, $urandom, $urandom);
            end else if (k < 75) begin
                w = make_word(FUNC_READ, $urandom_range(0, 1023), $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            end else if (k < 92) begin
                w = make_word(FUNC_LOAD, a, $urandom, $urandom,
                              rand_pos(), rand_pos(), rand_pos());
            end else begin
                w = make_word(FUNC_NOP, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            end
            send_word(w);
        end

        // drop valid after the last word, then drain
        @(negedge aclk);
        s_valid <= 1'b0;
        while (normal_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #1000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
